### design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes and field widths for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Field widths of the input and result words
    localparam int DATA_W   = 32;
    localparam int POS_W    = 9;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

endpackage

### design/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// List entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ple_ram
    import ple_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Operation sequencer: decodes a word, clamps the position, walks the entry
// store one entry per cycle to open or close a gap, and loads the result.
// ----------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input word
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            op,
    input  logic signed [DATA_W-1:0]   value,
    input  logic signed [POS_W-1:0]    position,
    // result word
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DATA_W-1:0]   read_value,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         entry_count,
    // entry store
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [DATA_W-1:0]          ram_wdata,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_raddr,
    input  logic [DATA_W-1:0]          ram_rdata
);

    // Signed compare width that holds both the position and the size
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_FILL   = 5'b00100,
        S_PEEK   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [DATA_W-1:0]     value_reg, value_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         rd_addr_reg, rd_addr_next;
    logic [CW-1:0]         rd_left_reg, rd_left_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [CW-1:0]         size_reg, size_next;
    logic [CW-1:0]         new_size_reg, new_size_next;
    logic [DATA_W-1:0]     res_value_reg, res_value_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     out_value_reg, out_value_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic signed [PW-1:0]  pos_x;
    logic signed [PW-1:0]  size_x;
    logic signed [PW-1:0]  del_lim_x;
    logic [AW-1:0]         ins_idx;
    logic [AW-1:0]         del_idx;
    logic                  peek_ok;
    logic                  out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Position decode and clamping
    assign pos_x     = PW'(position);
    assign size_x    = $signed(PW'(size_reg));
    assign del_lim_x = size_x - PW'(1);
    assign is_full   = (size_reg == CW'(DEPTH));
    assign is_empty  = (size_reg == '0);
    assign peek_ok   = (pos_x >= 0) && (pos_x < size_x);

    always_comb
    begin
        if (pos_x <= 0)
            ins_idx = '0;
        else if (pos_x >= size_x)
            ins_idx = AW'(size_x);
        else
            ins_idx = AW'(pos_x);

        if (pos_x <= 0)
            del_idx = '0;
        else if (pos_x >= del_lim_x)
            del_idx = AW'(del_lim_x);
        else
            del_idx = AW'(pos_x);
    end

    // Sequencer and store access
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        rd_addr_next    = rd_addr_reg;
        rd_left_next    = rd_left_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        size_next       = size_reg;
        new_size_next   = new_size_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg;

        // result word taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op;
                    value_next      = value;
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    new_size_next   = size_reg;
                    pend_next       = 1'b0;
                    rd_left_next    = '0;
                    state_next      = S_FINISH;
                    case (op)
                        OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                // move entries idx..size-1 back by one, top first
                                idx_next      = ins_idx;
                                rd_addr_next  = AW'(size_reg - CW'(1));
                                rd_left_next  = size_reg - CW'(ins_idx);
                                new_size_next = size_reg + CW'(1);
                                state_next    = S_SHIFT;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // move entries idx+1..size-1 forward by one
                                idx_next      = del_idx;
                                rd_addr_next  = del_idx + AW'(1);
                                rd_left_next  = size_reg - CW'(1) - CW'(del_idx);
                                new_size_next = size_reg - CW'(1);
                                state_next    = S_SHIFT;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (peek_ok)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'($unsigned(position));
                                state_next = S_PEEK;
                            end
                            else
                            begin
                                res_status_next = ST_BAD_POS;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // write back the entry read last cycle
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                // issue the next read
                if (rd_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_addr_reg;
                    rd_left_next = rd_left_reg - CW'(1);
                    pend_next    = 1'b1;
                    if (op_reg == OP_INSERT)
                    begin
                        rd_addr_next   = rd_addr_reg - AW'(1);
                        pend_addr_next = rd_addr_reg + AW'(1);
                    end
                    else
                    begin
                        rd_addr_next   = rd_addr_reg + AW'(1);
                        pend_addr_next = rd_addr_reg - AW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = (op_reg == OP_INSERT) ? S_FILL : S_FINISH;
                end
            end

            S_FILL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = value_reg;
                state_next = S_FINISH;
            end

            S_PEEK:
            begin
                res_value_next = ram_rdata;
                state_next     = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = COUNT_W'(new_size_reg);
                    size_next       = new_size_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_left_reg   <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            rd_left_reg   <= rd_left_next;
            pend_reg      <= pend_next;
        end
    end

    // Payload and address registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        rd_addr_reg    <= rd_addr_next;
        pend_addr_reg  <= pend_addr_next;
        new_size_reg   <= new_size_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = $signed(out_value_reg);
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

endmodule

### design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with insert, delete and peek at a
// position, held in a single-port-write, single-port-read entry store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in      | input     | in_valid/in_ready   | op, value, position
//  out     | output    | out_valid/out_ready | read_value, status, entry_count
//
//  One word at a time. An insert or delete walks the shift state (an insert
//  then the fill state), a peek the peek state; a flagged or unused op goes
//  straight to the finish state, which loads the result. The gap is opened
//  or closed one entry per cycle through the store's read port.
//  Next word is taken the cycle after the result is loaded; the result
//  register waits for out_ready without blocking that accept.
//  Reset clears the size; entries above the size are never read.
// ----------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          op,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [POS_W-1:0]  position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] read_value,
    output logic [STATUS_W-1:0]      status,
    output logic [COUNT_W-1:0]       entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Sequencer
    ple_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // Entry store
    ple_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### design/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks for the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker
    import ple_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] read_value,
    input logic [STATUS_W-1:0]      status,
    input logic [COUNT_W-1:0]       entry_count
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value)
            && $stable(status) && $stable(entry_count))
        else $error("result word changed while stalled");

    // One word in flight: ready drops right after an accept
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in flight");

    // A full flag reports a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == COUNT_W'(DEPTH))
        else $error("full status with count below depth");

    // An empty flag reports an empty list
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> entry_count == '0)
        else $error("empty status with nonzero count");

    // Any flagged result carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == '0)
        else $error("flagged result with nonzero value");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
);
